[src/backlight_idle_dim_controller_macros.svh]
// Assertion macros shared by the backlight idle dim controller RTL.
`ifndef BACKLIGHT_IDLE_DIM_CONTROLLER_MACROS_SVH
`define BACKLIGHT_IDLE_DIM_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define BIDC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define BIDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BIDC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define BIDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[src/bidc_pkg.sv]
// Types and constants of the backlight idle dim controller.
package bidc_pkg;

  typedef enum logic [1:0] {
    MODE_RESET  = 2'd0,
    MODE_SPLASH = 2'd1,
    MODE_LIT    = 2'd2,
    MODE_DIM    = 2'd3
  } mode_t;

  localparam logic [7:0] FULL_LEVEL = 8'd255;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLASH_SECONDS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SECONDS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_STEP_MILLIS = 2'd2;

  typedef struct packed {
    logic [15:0] splash_seconds;
    logic [15:0] idle_seconds;
    logic [15:0] dim_step_millis;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_seconds;
    logic [31:0] now_millis;
    logic        presence;
  } poll_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] switch_time;
    logic [31:0] refresh_time;
    logic [31:0] dim_time;
    logic [7:0]  level;
  } ctrl_state_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] light_level;
    logic       draw_splash;
    logic       refresh_view;
  } result_t;

endpackage

[src/bidc_poll_if.sv]
// Poll channel: timestamps and presence flag into the controller.
interface bidc_poll_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_seconds;
  logic [31:0] now_millis;
  logic        presence;

  modport source (output valid, output now_seconds, output now_millis,
                  output presence, input ready);
  modport sink (input valid, input now_seconds, input now_millis,
                input presence, output ready);
endinterface

[src/bidc_result_if.sv]
// Result channel: mode, level and redraw pulses out of the controller.
interface bidc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] light_level;
  logic       draw_splash;
  logic       refresh_view;

  modport source (output valid, output mode, output light_level,
                  output draw_splash, output refresh_view, input ready);
  modport sink (input valid, input mode, input light_level,
                input draw_splash, input refresh_view, output ready);
endinterface

[src/bidc_cfg_if.sv]
// Configuration write channel: register index and write data.
interface bidc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/bidc_cfg_regs.sv]
// Configuration register file of the backlight idle dim controller.
module bidc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  bidc_cfg_if.sink      cfg,
  output bidc_pkg::cfg_t regs
);
  import bidc_pkg::*;

  // Always take a word; the user must write only while the controller is idle, the block does not enforce it
  assign cfg.ready = 1'b1;

  // Update the addressed register, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.splash_seconds  <= 16'd5;
      regs.idle_seconds    <= 16'd30;
      regs.dim_step_millis <= 16'd20;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_SPLASH_SECONDS:  regs.splash_seconds  <= cfg.data;
        CFG_IDLE_SECONDS:    regs.idle_seconds    <= cfg.data;
        CFG_DIM_STEP_MILLIS: regs.dim_step_millis <= cfg.data;
        default: ;
      endcase
    end
  end
endmodule

[src/bidc_step.sv]
// Next-state and result logic for one poll word of the controller.
module bidc_step (
  input  bidc_pkg::ctrl_state_t cur,
  input  bidc_pkg::cfg_t        cfg,
  input  bidc_pkg::poll_t       poll,
  output bidc_pkg::ctrl_state_t nxt,
  output bidc_pkg::result_t     res
);
  import bidc_pkg::*;

  logic [31:0] elapsed_s;
  logic [31:0] elapsed_ms;
  logic        refresh_due;
  logic        draw;
  logic        refresh;

  // Elapsed times wrap modulo 2^32; the refresh test is a plain compare
  assign elapsed_s   = poll.now_seconds - cur.switch_time;
  assign elapsed_ms  = poll.now_millis - cur.dim_time;
  assign refresh_due = poll.now_seconds > cur.refresh_time;

  // Advance the mode machine
  always_comb begin
    nxt     = cur;
    draw    = 1'b0;
    refresh = 1'b0;
    case (cur.mode)
      MODE_RESET: begin
        draw             = 1'b1;
        nxt.mode         = MODE_SPLASH;
        nxt.switch_time  = poll.now_seconds;
        nxt.refresh_time = poll.now_seconds;
      end
      MODE_SPLASH: begin
        if (elapsed_s > {16'd0, cfg.splash_seconds}) begin
          nxt.mode        = MODE_LIT;
          nxt.switch_time = poll.now_seconds;
        end
      end
      MODE_LIT: begin
        if (refresh_due) begin
          refresh          = 1'b1;
          nxt.refresh_time = poll.now_seconds;
        end
        if (elapsed_s > {16'd0, cfg.idle_seconds}) begin
          nxt.mode        = MODE_DIM;
          nxt.switch_time = poll.now_seconds;
          nxt.dim_time    = poll.now_millis;
        end
        // Presence restarts the idle timer
        if (poll.presence) begin
          nxt.switch_time = poll.now_seconds;
        end
      end
      MODE_DIM: begin
        if (refresh_due) begin
          refresh          = 1'b1;
          nxt.refresh_time = poll.now_seconds;
        end
        if (elapsed_ms > {16'd0, cfg.dim_step_millis} && cur.level != 8'd0) begin
          nxt.level    = cur.level - 8'd1;
          nxt.dim_time = poll.now_millis;
        end
        // Presence wakes the light back to full
        if (poll.presence) begin
          nxt.mode        = MODE_LIT;
          nxt.level       = FULL_LEVEL;
          nxt.switch_time = poll.now_seconds;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign res.mode         = nxt.mode;
  assign res.light_level  = nxt.level;
  assign res.draw_splash  = draw;
  assign res.refresh_view = refresh;
endmodule

[src/backlight_idle_dim_controller.sv]
// Top level of the backlight idle dim controller.
//
//   channel  dir  handshake        payload
//   poll     in   valid / ready    now_seconds, now_millis, presence
//   result   out  valid / ready    mode, light_level, draw_splash, refresh_view
//   cfg      in   valid / ready    index, data (always ready)
//
// One poll word per clock when the result is not stalled: input register,
// one pass of step logic, result register, which sets result valid when loaded.
// The step logic updates the controller state in the same edge that loads
// the result register, so each word sees the state left by the one before.
// A stalled result holds the input register; poll ready drops only when both
// registers are full and the result is not taken. Synchronous reset puts the
// controller in reset mode at full level and the registers at their defaults.
`include "backlight_idle_dim_controller_macros.svh"

module backlight_idle_dim_controller (
  input  logic            clk,
  input  logic            rst,
  bidc_poll_if.sink       poll,
  bidc_result_if.source   result,
  bidc_cfg_if.sink        cfg
);
  import bidc_pkg::*;

  cfg_t        cfg_regs;
  poll_t       in_q;
  logic        in_valid;
  ctrl_state_t state;
  ctrl_state_t state_next;
  result_t     step_res;
  result_t     out_q;
  logic        out_valid;
  logic        advance;

  bidc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  bidc_step u_step (
    .cur  (state),
    .cfg  (cfg_regs),
    .poll (in_q),
    .nxt  (state_next),
    .res  (step_res)
  );

  // Move a word from the input register when the result register frees up
  assign advance    = in_valid && (!out_valid || result.ready);
  assign poll.ready = !in_valid || advance;

  // Hold the incoming poll word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      in_q.now_seconds <= poll.now_seconds;
      in_q.now_millis  <= poll.now_millis;
      in_q.presence    <= poll.presence;
    end
  end

  // Commit controller state for each processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode         <= MODE_RESET;
      state.switch_time  <= 32'd0;
      state.refresh_time <= 32'd0;
      state.dim_time     <= 32'd0;
      state.level        <= FULL_LEVEL;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.mode         = out_q.mode;
  assign result.light_level  = out_q.light_level;
  assign result.draw_splash  = out_q.draw_splash;
  assign result.refresh_view = out_q.refresh_view;

  // Checks on the controller's own behavior
  `BIDC_ASSERT_NEXT(a_advance_gives_result, clk, rst, advance, out_valid,
    "word processed but no result held")
  `BIDC_ASSERT_NOW(a_reset_mode_full, clk, rst, state.mode == MODE_RESET,
    state.level == FULL_LEVEL, "reset mode below full level")
  `BIDC_ASSERT_NOW(a_splash_only_entering, clk, rst, out_valid && out_q.draw_splash,
    out_q.mode == MODE_SPLASH, "splash drawn outside splash entry")
  `BIDC_ASSERT_NOW(a_refresh_when_shown, clk, rst, out_valid && out_q.refresh_view,
    out_q.mode == MODE_LIT || out_q.mode == MODE_DIM, "view refresh during reset or splash")
endmodule

[tb/sv/tb_backlight_idle_dim_controller.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the backlight idle dim controller.
module tb_backlight_idle_dim_controller;
  import bidc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 6;

  // Track controller state and queue the result word each poll word must produce.
  class light_scoreboard;
    cfg_t        regs;
    mode_t       mode;
    logic [31:0] switch_time;
    logic [31:0] refresh_time;
    logic [31:0] dim_time;
    logic [7:0]  level;
    result_t     pending_q[$];
    int          errors;

    function new();
      regs.splash_seconds = 16'd5;
      regs.idle_seconds = 16'd30;
      regs.dim_step_millis = 16'd20;
      mode = MODE_RESET;
      switch_time = '0;
      refresh_time = '0;
      dim_time = '0;
      level = FULL_LEVEL;
      errors = 0;
    endfunction

    // Apply a register write; drop writes to unknown indexes.
    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [15:0] data);
      case (index)
        CFG_SPLASH_SECONDS:  regs.splash_seconds = data;
        CFG_IDLE_SECONDS:    regs.idle_seconds = data;
        CFG_DIM_STEP_MILLIS: regs.dim_step_millis = data;
        default: ;
      endcase
    endfunction

    // Advance the mode machine by one poll word and queue the expected result.
    function void note_poll(poll_t p);
      result_t     r;
      logic [31:0] secs_gone;
      logic [31:0] ms_gone;
      secs_gone = p.now_seconds - switch_time;
      ms_gone = p.now_millis - dim_time;
      r.draw_splash = 1'b0;
      r.refresh_view = 1'b0;
      case (mode)
        MODE_RESET: begin
          r.draw_splash = 1'b1;
          mode = MODE_SPLASH;
          switch_time = p.now_seconds;
          refresh_time = p.now_seconds;
        end
        MODE_SPLASH: begin
          if (secs_gone > {16'd0, regs.splash_seconds}) begin
            mode = MODE_LIT;
            switch_time = p.now_seconds;
          end
        end
        MODE_LIT: begin
          if (p.now_seconds > refresh_time) begin
            r.refresh_view = 1'b1;
            refresh_time = p.now_seconds;
          end
          if (secs_gone > {16'd0, regs.idle_seconds}) begin
            mode = MODE_DIM;
            switch_time = p.now_seconds;
            dim_time = p.now_millis;
          end
          if (p.presence) switch_time = p.now_seconds;
        end
        default: begin
          if (p.now_seconds > refresh_time) begin
            r.refresh_view = 1'b1;
            refresh_time = p.now_seconds;
          end
          // Step down once per elapsed interval, hold at zero.
          if (ms_gone > {16'd0, regs.dim_step_millis} && level != 8'd0) begin
            level = level - 8'd1;
            dim_time = p.now_millis;
          end
          // Wake to full level; this wins over a decrement in the same word.
          if (p.presence) begin
            mode = MODE_LIT;
            level = FULL_LEVEL;
            switch_time = p.now_seconds;
          end
        end
      endcase
      r.mode = mode;
      r.light_level = level;
      pending_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare a delivered result word with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual mode %0d level %0d",
                 $time, got.mode, got.light_level);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      compare_field("mode", 32'(want.mode), 32'(got.mode));
      compare_field("light_level", 32'(want.light_level), 32'(got.light_level));
      compare_field("draw_splash", 32'(want.draw_splash), 32'(got.draw_splash));
      compare_field("refresh_view", 32'(want.refresh_view), 32'(got.refresh_view));
    endfunction
  endclass

  logic clk;
  logic rst;

  bidc_poll_if   poll_bus();
  bidc_result_if result_bus();
  bidc_cfg_if    cfg_bus();

  backlight_idle_dim_controller dut (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  light_scoreboard light_sb;
  bit              hold_request = 1'b0;
  int unsigned     burst_left = 0;
  int unsigned     cur_idle = 0;
  int unsigned     cur_dim = 0;
  logic [31:0]     clock_s = '0;
  logic [31:0]     clock_ms = '0;
  int unsigned     cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words outstanding", $time,
               light_sb.pending_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Note every accepted poll word.
  always @(posedge clk) begin
    if (!rst && poll_bus.valid && poll_bus.ready)
      light_sb.note_poll({poll_bus.now_seconds, poll_bus.now_millis, poll_bus.presence});
  end

  // Check every accepted result word.
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      light_sb.check_result({result_bus.mode, result_bus.light_level,
                             result_bus.draw_splash, result_bus.refresh_view});
  end

  // Stall the result side on a changing pattern, with one long hold-off on request.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned stall_pct;
    int unsigned pattern_age;
    hold_left = 0;
    stall_pct = 0;
    pattern_age = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(16, 96);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 70;
        endcase
      end
      pattern_age--;
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one poll word, then idle between bursts.
  task automatic send_poll(input poll_t p);
    int unsigned gap;
    poll_bus.valid <= 1'b1;
    poll_bus.now_seconds <= p.now_seconds;
    poll_bus.now_millis <= p.now_millis;
    poll_bus.presence <= p.presence;
    do @(posedge clk); while (!poll_bus.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        poll_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Wait until every expected result word has come back, then settle.
  task automatic drain();
    poll_bus.valid <= 1'b0;
    @(posedge clk);
    while (light_sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [15:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    light_sb.write_reg(index, data);
  endtask

  // Reprogram all registers on an idle block; also poke the unused index.
  task automatic set_regs(input logic [15:0] splash, input logic [15:0] idle_secs,
                          input logic [15:0] dim_ms);
    drain();
    write_reg(CFG_SPLASH_SECONDS, splash);
    write_reg(CFG_IDLE_SECONDS, idle_secs);
    write_reg(CFG_DIM_STEP_MILLIS, dim_ms);
    write_reg(CFG_UNUSED_INDEX, 16'($urandom()));
    cfg_bus.valid <= 1'b0;
    cur_idle = 32'(idle_secs);
    cur_dim = 32'(dim_ms);
  endtask

  // Build the next poll word: mostly advancing clocks, some jumps and junk.
  function automatic poll_t next_poll(int unsigned presence_pct, int unsigned noise_pct);
    poll_t       p;
    int unsigned roll;
    p.presence = ($urandom_range(0, 99) < presence_pct);
    roll = $urandom_range(0, 99);
    if (roll < noise_pct) begin
      case ($urandom_range(0, 2))
        0: clock_s = clock_s - $urandom_range(1, 5);
        1: begin
          clock_s = $urandom();
          clock_ms = $urandom();
        end
        default: begin
          p.now_seconds = $urandom();
          p.now_millis = $urandom();
          p.presence = 1'($urandom_range(0, 1));
          return p;
        end
      endcase
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) clock_s = clock_s + $urandom_range(0, 2);
      else if (roll < 95) clock_s = clock_s + $urandom_range(0, cur_idle + 2);
      else clock_s = clock_s + $urandom();
      roll = $urandom_range(0, 99);
      if (roll < 60) clock_ms = clock_ms + cur_dim + $urandom_range(1, 3);
      else if (roll < 85) clock_ms = clock_ms + $urandom_range(0, cur_dim);
      else clock_ms = clock_ms + $urandom_range(0, 2 * cur_dim + 1000);
    end
    p.now_seconds = clock_s;
    p.now_millis = clock_ms;
    return p;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned presence_pct,
                            input int unsigned noise_pct);
    repeat (count) send_poll(next_poll(presence_pct, noise_pct));
  endtask

  initial begin
    light_sb = new();
    rst <= 1'b1;
    poll_bus.valid <= 1'b0;
    poll_bus.now_seconds <= '0;
    poll_bus.now_millis <= '0;
    poll_bus.presence <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_SPLASH_SECONDS;
    cfg_bus.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed walk: splash 2 s, idle 3 s, step 5 ms.
    set_regs(16'd2, 16'd3, 16'd5);
    send_poll({32'd100, 32'd1000, 1'b1});          // reset step, presence ignored
    send_poll({32'd102, 32'd1002, 1'b1});          // splash not yet exceeded
    send_poll({32'd103, 32'd1003, 1'b0});          // enter lit
    send_poll({32'd104, 32'd1004, 1'b0});          // refresh
    send_poll({32'd104, 32'd1005, 1'b0});          // same second, no refresh
    send_poll({32'd107, 32'd1010, 1'b1});          // idle exceeded with presence
    send_poll({32'd107, 32'd1016, 1'b0});          // one step down
    send_poll({32'd108, 32'd1021, 1'b0});          // step equal to limit, hold
    send_poll({32'd108, 32'd1027, 1'b1});          // decrement overridden by wake
    send_poll({32'd50, 32'd1028, 1'b0});           // clock backwards, wrapped idle
    send_poll({32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0});
    send_poll({32'd0, 32'd4, 1'b0});               // millis wrap, equal to limit
    send_poll({32'd0, 32'd5, 1'b0});
    send_poll({32'hFFFF_FFFF, 32'd5, 1'b1});
    send_poll({32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0});
    send_poll({32'd2, 32'd0, 1'b0});               // wrapped idle, not exceeded
    send_poll({32'd3, 32'd0, 1'b0});               // wrapped idle, exceeded

    // Random phases across register settings, first one under a long hold-off.
    clock_s = 32'd10;
    clock_ms = '0;
    hold_request = 1'b1;
    run_random(350, 4, 10);
    set_regs(16'd0, 16'd0, 16'd0);
    run_random(300, 10, 15);
    set_regs(16'hFFFF, 16'd1, 16'd0);
    run_random(450, 0, 0);
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(300, 5, 15);
    set_regs(16'($urandom()), 16'($urandom_range(0, 40)), 16'($urandom()));
    run_random(350, 5, 10);

    drain();
    if (light_sb.errors == 0 && light_sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/bidc_pkg.sv
src/bidc_poll_if.sv
src/bidc_result_if.sv
src/bidc_cfg_if.sv
src/bidc_cfg_regs.sv
src/bidc_step.sv
src/backlight_idle_dim_controller.sv
tb/sv/tb_backlight_idle_dim_controller.sv
